// ===== src/arcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// arcpr_pkg
// Shared types and codes of the ARC page replacer.
// ----------------------------------------------------------------------------
package arcpr_pkg;

   localparam int FRAMES_DEF    = 64;
   localparam int PAGE_BITS_DEF = 32;

   localparam int CAP_W = 7;
   localparam int CNT_OUT_W = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] CMD_ACCESS    = 2'd0;
   localparam logic [1:0] CMD_SET_EVICT = 2'd1;
   localparam logic [1:0] CMD_REMOVE    = 2'd2;
   localparam logic [1:0] CMD_EVICT     = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NO_VICTIM = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN   = 2'd2;

   localparam logic [1:0] LIST_NONE   = 2'd0;
   localparam logic [1:0] LIST_RECENT = 2'd1;
   localparam logic [1:0] LIST_FREQ   = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  frame_index;
      logic [31:0] page_number;
      logic        evictable_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [5:0]           victim_frame;
      logic [CNT_OUT_W-1:0] evictable_count;
   } rsp_type;

endpackage

// ===== src/arc_page_replacer.sv =====
// ----------------------------------------------------------------------------
// arc_page_replacer
// ARC victim selector: recent/frequent frame lists, two ghost lists, target.
// ----------------------------------------------------------------------------
// One command word at a time. Frame state lives in a FRAMES-deep RAM and ghost
// state in a 2*FRAMES-deep RAM; every list update is a read-modify-write sweep
// over one of them, one entry a cycle. Set evictable reads and rewrites one
// frame entry; remove of a live evictable frame and a live access sweep the
// frame RAM; a miss sweeps the ghost RAM and then the frame RAM, with a ghost
// update sweep between them when a ghost is trimmed; a ghost hit sweeps the
// ghost RAM, runs up to clog2(2*FRAMES+1) divider steps, then sweeps the ghost
// and frame RAMs; evict scans the frame RAM, then runs the same three sweeps.
// The next command word is taken once the result sits in the output register.
module arc_page_replacer import arcpr_pkg::*; #(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int GHOSTS = 2 * FRAMES;
   localparam int FAW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int GAW = $clog2(GHOSTS);
   localparam int CW  = $clog2(GHOSTS + 1);
   localparam int ETW = $clog2(FRAMES + 1);
   localparam int SW  = ((CW > CAP_W) ? CW : CAP_W) + 1;
   localparam int DCW = $clog2(CW + 1);

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic [1:0]           lst;
      logic                 ev;
      logic [FAW-1:0]       rank;
   } fent_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic [1:0]           lst;
      logic [GAW-1:0]       rank;
   } gent_type;

   typedef struct packed {
      logic           dec_en;
      logic [1:0]     dec_list;
      logic [FAW-1:0] dec_rank;
      logic           inc_en;
      logic [1:0]     inc_list;
      logic [FAW-1:0] idx;
      logic [1:0]     new_list;
      logic           new_ev;
      logic           new_page_en;
   } fop_type;

   typedef struct packed {
      logic           clr_en;
      logic [GAW-1:0] clr_idx;
      logic           dec_en;
      logic [1:0]     dec_list;
      logic [GAW-1:0] dec_rank;
      logic           wr_en;
      logic [GAW-1:0] wr_idx;
      logic [1:0]     lst;
      logic           inc_en;
   } gop_type;

   localparam int FWORD = $bits(fent_type);
   localparam int GWORD = $bits(gent_type);

   typedef enum logic [3:0] {
      S_IDLE, S_FRD0, S_FRD1, S_FSCAN, S_GFIND, S_DIV, S_TGT, S_GUPD, S_FUPD, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [FAW-1:0]       fidx_ff, fidx_in;
   logic                 flag_ff, flag_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   fop_type              fop_ff, fop_in;
   gop_type              gop_ff, gop_in;
   logic [CW-1:0]        lc_ff [4];
   logic [CW-1:0]        lc_in [4];
   logic [CAP_W-1:0]     tgt_ff, tgt_in;
   logic [ETW-1:0]       et_ff, et_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic [FRAMES-1:0]    fvld_ff, fvld_in;
   logic [GHOSTS-1:0]    gvld_ff, gvld_in;
   logic                 f_rv_ff, g_rv_ff;
   logic                 gf_found_ff, gf_found_in;
   logic [GAW-1:0]       gf_idx_ff, gf_idx_in;
   logic [1:0]           gf_list_ff, gf_list_in;
   logic [GAW-1:0]       gf_rank_ff, gf_rank_in;
   logic                 ge_found_ff, ge_found_in;
   logic [GAW-1:0]       ge_idx_ff, ge_idx_in;
   logic [GAW-1:0]       go1_ff, go1_in, go2_ff, go2_in;
   logic [1:0]           bf_ff, bf_in;
   logic [FAW-1:0]       bi_ff [2];
   logic [FAW-1:0]       bi_in [2];
   logic [FAW-1:0]       br_ff [2];
   logic [FAW-1:0]       br_in [2];
   logic [PAGE_BITS-1:0] bp_ff [2];
   logic [PAGE_BITS-1:0] bp_in [2];
   logic [1:0]           ev_list_ff, ev_list_in;
   logic [FAW-1:0]       ev_idx_ff, ev_idx_in;
   logic [FAW-1:0]       ev_rank_ff, ev_rank_in;
   logic [CW-1:0]        rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic                 up_ff, up_in;
   logic [1:0]           stat_ff, stat_in;
   logic [5:0]           victim_ff, victim_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic             f_we, g_we;
   logic [FAW-1:0]   f_waddr, f_raddr;
   logic [GAW-1:0]   g_waddr, g_raddr;
   logic [FWORD-1:0] f_wdata, f_rdata;
   logic [GWORD-1:0] g_wdata, g_rdata;

   arcpr_ram #(.WIDTH(FWORD), .DEPTH(FRAMES)) u_frame_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   arcpr_ram #(.WIDTH(GWORD), .DEPTH(GHOSTS)) u_ghost_ram (
      .clock (clock),
      .we    (g_we),
      .waddr (g_waddr),
      .wdata (g_wdata),
      .raddr (g_raddr),
      .rdata (g_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? 32'd0 : 32'(cap_ff);

   always_comb begin
      logic [CW-1:0]   pcnt;
      logic [FAW-1:0]  pf;
      logic [GAW-1:0]  pg;
      fent_type        fe, fw;
      gent_type        ge, gw;
      logic [1:0]      k, lst, oth, li;
      logic [CW:0]     rsz;
      logic [CW+1:0]   all;
      logic [CW:0]     rs;
      logic [SW-1:0]   s;
      logic            need, qb, pref1;
      logic [CW-1:0]   num;

      state_in = state_ff;
      cmd_in = cmd_ff;
      fidx_in = fidx_ff;
      flag_in = flag_ff;
      page_in = page_ff;
      cnt_in = cnt_ff;
      fop_in = fop_ff;
      gop_in = gop_ff;
      lc_in = lc_ff;
      tgt_in = tgt_ff;
      et_in = et_ff;
      cap_in = cap_ff;
      fvld_in = fvld_ff;
      gvld_in = gvld_ff;
      gf_found_in = gf_found_ff;
      gf_idx_in = gf_idx_ff;
      gf_list_in = gf_list_ff;
      gf_rank_in = gf_rank_ff;
      ge_found_in = ge_found_ff;
      ge_idx_in = ge_idx_ff;
      go1_in = go1_ff;
      go2_in = go2_ff;
      bf_in = bf_ff;
      bi_in = bi_ff;
      br_in = br_ff;
      bp_in = bp_ff;
      ev_list_in = ev_list_ff;
      ev_idx_in = ev_idx_ff;
      ev_rank_in = ev_rank_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      dcnt_in = dcnt_ff;
      up_in = up_ff;
      stat_in = stat_ff;
      victim_in = victim_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      pcnt = cnt_ff - 1'b1;
      pf = pcnt[FAW-1:0];
      pg = pcnt[GAW-1:0];
      fe = fent_type'(f_rdata);
      if (!f_rv_ff) begin
         fe.lst = LIST_NONE;
         fe.ev = 1'b0;
         fe.rank = '0;
      end
      ge = gent_type'(g_rdata);
      if (!g_rv_ff) begin
         ge.lst = LIST_NONE;
         ge.rank = '0;
      end
      fw = fe;
      gw = ge;
      k = 2'd0;
      lst = LIST_NONE;
      oth = LIST_NONE;
      li = 2'd0;
      rsz = '0;
      all = '0;
      rs = '0;
      s = '0;
      need = 1'b0;
      qb = 1'b0;
      pref1 = 1'b0;
      num = '0;

      f_we = 1'b0;
      f_waddr = pf;
      f_wdata = '0;
      f_raddr = cnt_ff[FAW-1:0];
      g_we = 1'b0;
      g_waddr = pg;
      g_wdata = '0;
      g_raddr = cnt_ff[GAW-1:0];

      if (psel && penable && pwrite && !paddr[2]) begin
         cap_in = pwdata[CAP_W-1:0];
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data.cmd;
               fidx_in = FAW'(req_data.frame_index);
               flag_in = req_data.evictable_flag;
               page_in = PAGE_BITS'(req_data.page_number);
               cnt_in = '0;
               stat_in = STAT_OK;
               victim_in = '0;
               if (req_data.cmd == CMD_EVICT) begin
                  bf_in = '0;
                  state_in = S_FSCAN;
               end else if (int'(req_data.frame_index) >= FRAMES) begin
                  if (req_data.cmd == CMD_SET_EVICT) begin
                     stat_in = STAT_UNKNOWN;
                  end
                  state_in = S_DONE;
               end else begin
                  state_in = S_FRD0;
               end
            end
         end
         S_FRD0: begin
            f_raddr = fidx_ff;
            state_in = S_FRD1;
         end
         S_FRD1: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_SET_EVICT: begin
                  if (fe.lst == LIST_NONE) begin
                     stat_in = STAT_UNKNOWN;
                  end else begin
                     fw.ev = flag_ff;
                     f_we = 1'b1;
                     f_waddr = fidx_ff;
                     f_wdata = fw;
                     if (!fe.ev && flag_ff) begin
                        et_in = et_ff + 1'b1;
                     end
                     if (fe.ev && !flag_ff && et_ff != '0) begin
                        et_in = et_ff - 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (fe.lst != LIST_NONE && fe.ev) begin
                     fop_in = '{1'b1, fe.lst, fe.rank, 1'b0, LIST_NONE, fidx_ff,
                                LIST_NONE, 1'b0, 1'b0};
                     li = fe.lst - 1'b1;
                     lc_in[li] = lc_ff[li] - 1'b1;
                     if (et_ff != '0) begin
                        et_in = et_ff - 1'b1;
                     end
                     cnt_in = '0;
                     state_in = S_FUPD;
                  end
               end
               default: begin
                  cnt_in = '0;
                  if (fe.lst != LIST_NONE) begin
                     fop_in = '{1'b1, fe.lst, fe.rank, 1'b1, LIST_FREQ, fidx_ff,
                                LIST_FREQ, fe.ev, 1'b0};
                     li = fe.lst - 1'b1;
                     lc_in[li] = lc_ff[li] - 1'b1;
                     lc_in[1] = lc_in[1] + 1'b1;
                     state_in = S_FUPD;
                  end else begin
                     gf_found_in = 1'b0;
                     ge_found_in = 1'b0;
                     state_in = S_GFIND;
                  end
               end
            endcase
         end
         S_FSCAN: begin
            if (cnt_ff != '0 && fe.lst != LIST_NONE && fe.ev) begin
               k = (fe.lst == LIST_FREQ) ? 2'd1 : 2'd0;
               if (!bf_ff[k[0]] || fe.rank > br_ff[k[0]]) begin
                  bf_in[k[0]] = 1'b1;
                  bi_in[k[0]] = pf;
                  br_in[k[0]] = fe.rank;
                  bp_in[k[0]] = fe.page;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(FRAMES)) begin
               pref1 = (SW'(lc_ff[0]) >= SW'(tgt_ff));
               k = 2'd0;
               if (pref1) begin
                  k = bf_in[0] ? 2'd0 : 2'd1;
               end else begin
                  k = bf_in[1] ? 2'd1 : 2'd0;
               end
               cnt_in = '0;
               if (!bf_in[k[0]]) begin
                  stat_in = STAT_NO_VICTIM;
                  state_in = S_DONE;
               end else begin
                  ev_list_in = k + 2'd1;
                  ev_idx_in = bi_in[k[0]];
                  ev_rank_in = br_in[k[0]];
                  page_in = bp_in[k[0]];
                  gf_found_in = 1'b0;
                  ge_found_in = 1'b0;
                  state_in = S_GFIND;
               end
            end
         end
         S_GFIND: begin
            if (cnt_ff != '0) begin
               if (ge.lst == LIST_NONE) begin
                  if (!ge_found_ff) begin
                     ge_found_in = 1'b1;
                     ge_idx_in = pg;
                  end
               end else begin
                  if (ge.page == page_ff && !gf_found_ff) begin
                     gf_found_in = 1'b1;
                     gf_idx_in = pg;
                     gf_list_in = ge.lst;
                     gf_rank_in = ge.rank;
                  end
                  if (ge.lst == LIST_RECENT && ge.rank == GAW'(lc_ff[2] - 1'b1)) begin
                     go1_in = pg;
                  end
                  if (ge.lst == LIST_FREQ && ge.rank == GAW'(lc_ff[3] - 1'b1)) begin
                     go2_in = pg;
                  end
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(GHOSTS)) begin
               cnt_in = '0;
               gop_in = '0;
               if (cmd_ff == CMD_ACCESS) begin
                  if (gf_found_in) begin
                     gop_in.clr_en = 1'b1;
                     gop_in.clr_idx = gf_idx_in;
                     gop_in.dec_en = 1'b1;
                     gop_in.dec_list = gf_list_in;
                     gop_in.dec_rank = gf_rank_in;
                     li = gf_list_in + 2'd1;
                     lc_in[li] = lc_ff[li] - 1'b1;
                     fop_in = '{1'b0, LIST_NONE, '0, 1'b1, LIST_FREQ, fidx_ff,
                                LIST_FREQ, 1'b1, 1'b1};
                     lc_in[1] = lc_ff[1] + 1'b1;
                     et_in = et_ff + 1'b1;
                     if (gf_list_in == LIST_RECENT) begin
                        up_in = 1'b1;
                        need = !(lc_ff[2] >= lc_ff[3] || lc_ff[2] == '0);
                        num = lc_ff[3];
                        den_in = lc_ff[2];
                     end else begin
                        up_in = 1'b0;
                        need = !(lc_ff[3] >= lc_ff[2] || lc_ff[3] == '0);
                        num = lc_ff[2];
                        den_in = lc_ff[3];
                     end
                     if (need) begin
                        rem_in = '0;
                        quo_in = num;
                        dcnt_in = '0;
                        state_in = S_DIV;
                     end else begin
                        quo_in = CW'(1);
                        state_in = S_TGT;
                     end
                  end else begin
                     fop_in = '{1'b0, LIST_NONE, '0, 1'b1, LIST_RECENT, fidx_ff,
                                LIST_RECENT, 1'b0, 1'b1};
                     lc_in[0] = lc_ff[0] + 1'b1;
                     rsz = (CW+1)'(lc_ff[0]) + (CW+1)'(lc_ff[2]);
                     all = (CW+2)'(rsz) + (CW+2)'(lc_ff[1]) + (CW+2)'(lc_ff[3]);
                     state_in = S_FUPD;
                     if (rsz == (CW+1)'(cap_ff)) begin
                        if (lc_ff[2] != '0) begin
                           gop_in.clr_en = 1'b1;
                           gop_in.clr_idx = go1_in;
                           lc_in[2] = lc_ff[2] - 1'b1;
                           state_in = S_GUPD;
                        end
                     end else if (all == ((CW+2)'(cap_ff) << 1)) begin
                        if (lc_ff[3] != '0) begin
                           gop_in.clr_en = 1'b1;
                           gop_in.clr_idx = go2_in;
                           lc_in[3] = lc_ff[3] - 1'b1;
                           state_in = S_GUPD;
                        end
                     end
                  end
               end else begin
                  lst = ev_list_ff;
                  oth = (lst == LIST_RECENT) ? LIST_FREQ : LIST_RECENT;
                  gop_in.lst = lst;
                  if (gf_found_in) begin
                     gop_in.wr_en = 1'b1;
                     gop_in.wr_idx = (ge_found_in && ge_idx_in < gf_idx_in) ?
                                     ge_idx_in : gf_idx_in;
                     gop_in.clr_en = (gop_in.wr_idx != gf_idx_in);
                     gop_in.clr_idx = gf_idx_in;
                     gop_in.dec_en = 1'b1;
                     gop_in.dec_list = gf_list_in;
                     gop_in.dec_rank = gf_rank_in;
                     li = gf_list_in + 2'd1;
                     lc_in[li] = lc_in[li] - 1'b1;
                  end else if (ge_found_in) begin
                     gop_in.wr_en = 1'b1;
                     gop_in.wr_idx = ge_idx_in;
                  end else if (lc_ff[lst + 2'd1] != '0) begin
                     gop_in.wr_en = 1'b1;
                     gop_in.wr_idx = (lst == LIST_RECENT) ? go1_in : go2_in;
                     li = lst + 2'd1;
                     lc_in[li] = lc_in[li] - 1'b1;
                  end else if (lc_ff[oth + 2'd1] != '0) begin
                     gop_in.wr_en = 1'b1;
                     gop_in.wr_idx = (oth == LIST_RECENT) ? go1_in : go2_in;
                     li = oth + 2'd1;
                     lc_in[li] = lc_in[li] - 1'b1;
                  end
                  if (gop_in.wr_en) begin
                     gop_in.inc_en = 1'b1;
                     li = lst + 2'd1;
                     lc_in[li] = lc_in[li] + 1'b1;
                  end
                  fop_in = '{1'b1, lst, ev_rank_ff, 1'b0, LIST_NONE, ev_idx_ff,
                             LIST_NONE, 1'b0, 1'b0};
                  li = lst - 2'd1;
                  lc_in[li] = lc_in[li] - 1'b1;
                  if (et_ff != '0) begin
                     et_in = et_ff - 1'b1;
                  end
                  victim_in = 6'(ev_idx_ff);
                  state_in = S_GUPD;
               end
            end
         end
         S_DIV: begin
            rs = {rem_ff, quo_ff[CW-1]};
            qb = (rs >= {1'b0, den_ff});
            rem_in = qb ? CW'(rs - {1'b0, den_ff}) : CW'(rs);
            quo_in = {quo_ff[CW-2:0], qb};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(CW - 1)) begin
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            if (up_ff) begin
               s = SW'(tgt_ff) + SW'(quo_ff);
               tgt_in = (s > SW'(cap_ff)) ? cap_ff : CAP_W'(s);
            end else begin
               s = SW'(tgt_ff) - SW'(quo_ff);
               tgt_in = (SW'(quo_ff) > SW'(tgt_ff)) ? '0 : CAP_W'(s);
            end
            cnt_in = '0;
            state_in = S_GUPD;
         end
         S_GUPD: begin
            if (cnt_ff != '0) begin
               if (gop_ff.wr_en && pg == gop_ff.wr_idx) begin
                  gw.page = page_ff;
                  gw.lst = gop_ff.lst;
                  gw.rank = '0;
                  g_we = 1'b1;
               end else if (gop_ff.clr_en && pg == gop_ff.clr_idx) begin
                  gw.lst = LIST_NONE;
                  gw.rank = '0;
                  g_we = 1'b1;
               end else if (ge.lst != LIST_NONE) begin
                  if (gop_ff.dec_en && ge.lst == gop_ff.dec_list &&
                      ge.rank > gop_ff.dec_rank) begin
                     gw.rank = gw.rank - 1'b1;
                  end
                  if (gop_ff.inc_en && ge.lst == gop_ff.lst) begin
                     gw.rank = gw.rank + 1'b1;
                  end
                  g_we = 1'b1;
               end
               g_wdata = gw;
               if (g_we) begin
                  gvld_in[pg] = 1'b1;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(GHOSTS)) begin
               cnt_in = '0;
               state_in = S_FUPD;
            end
         end
         S_FUPD: begin
            if (cnt_ff != '0) begin
               if (pf == fop_ff.idx) begin
                  if (fop_ff.new_page_en) begin
                     fw.page = page_ff;
                  end
                  fw.lst = fop_ff.new_list;
                  fw.ev = fop_ff.new_ev;
                  fw.rank = '0;
                  f_we = 1'b1;
               end else if (fe.lst != LIST_NONE) begin
                  if (fop_ff.dec_en && fe.lst == fop_ff.dec_list &&
                      fe.rank > fop_ff.dec_rank) begin
                     fw.rank = fw.rank - 1'b1;
                  end
                  if (fop_ff.inc_en && fe.lst == fop_ff.inc_list) begin
                     fw.rank = fw.rank + 1'b1;
                  end
                  f_we = 1'b1;
               end
               f_wdata = fw;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(FRAMES)) begin
               cnt_in = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = stat_ff;
               rsp_data_in.victim_frame = victim_ff;
               rsp_data_in.evictable_count = CNT_OUT_W'(et_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (f_we) begin
         fvld_in[f_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lc_ff <= '{default: '0};
         tgt_ff <= '0;
         et_ff <= '0;
         cap_ff <= CAP_RESET;
         fvld_ff <= '0;
         gvld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lc_ff <= lc_in;
         tgt_ff <= tgt_in;
         et_ff <= et_in;
         cap_ff <= cap_in;
         fvld_ff <= fvld_in;
         gvld_ff <= gvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      f_rv_ff <= fvld_ff[f_raddr];
      g_rv_ff <= gvld_ff[g_raddr];
      cmd_ff <= cmd_in;
      fidx_ff <= fidx_in;
      flag_ff <= flag_in;
      page_ff <= page_in;
      cnt_ff <= cnt_in;
      fop_ff <= fop_in;
      gop_ff <= gop_in;
      gf_found_ff <= gf_found_in;
      gf_idx_ff <= gf_idx_in;
      gf_list_ff <= gf_list_in;
      gf_rank_ff <= gf_rank_in;
      ge_found_ff <= ge_found_in;
      ge_idx_ff <= ge_idx_in;
      go1_ff <= go1_in;
      go2_ff <= go2_in;
      bf_ff <= bf_in;
      bi_ff <= bi_in;
      br_ff <= br_in;
      bp_ff <= bp_in;
      ev_list_ff <= ev_list_in;
      ev_idx_ff <= ev_idx_in;
      ev_rank_ff <= ev_rank_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      dcnt_ff <= dcnt_in;
      up_ff <= up_in;
      stat_ff <= stat_in;
      victim_ff <= victim_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/arcpr_ram.sv =====
// ----------------------------------------------------------------------------
// arcpr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module arcpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/arcpr_chk.sv =====
// ----------------------------------------------------------------------------
// arcpr_chk
// Port-level checks of the ARC page replacer, bound to the top level.
// ----------------------------------------------------------------------------
module arcpr_chk import arcpr_pkg::*; #(
   parameter int FRAMES = FRAMES_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   a_no_victim_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_NO_VICTIM |->
         rsp_data.victim_frame == '0 && rsp_data.evictable_count == '0)
      else $error("no victim reported with evictable frames present");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.evictable_count) <= FRAMES)
      else $error("evictable count above frame count");

endmodule

bind arc_page_replacer arcpr_chk #(.FRAMES(FRAMES)) u_arcpr_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_arc_page_replacer.sv =====
// ----------------------------------------------------------------------------
// tb_arc_page_replacer
// Self-checking bench for the ARC page replacer: directed table, then random
// command words across several capacities, all checked against a predictor.
// ----------------------------------------------------------------------------
module tb_arc_page_replacer;
   import arcpr_pkg::*;

   localparam int NF = 64;
   localparam int NG = 128;
   localparam int LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   arc_page_replacer dut (.*);

   initial forever #2 clock = ~clock;

   // predictor state
   logic [6:0]  p_cap;
   logic [31:0] f_page [NF];
   logic [1:0]  f_list [NF];
   logic        f_ev [NF];
   int          f_rank [NF];
   logic [31:0] g_page [NG];
   logic [1:0]  g_list [NG];
   int          g_rank [NG];
   int          p_target, p_evcnt;
   int          cnt [4];

   rsp_type pending_rsp [$];
   bit      failed = 0;
   bit      calm = 0;
   int      cycles = 0;

   function automatic void replacer_clear();
      p_cap = CAP_RESET;
      for (int i = 0; i < NF; i++) begin
         f_page[i] = '0; f_list[i] = LIST_NONE; f_ev[i] = 1'b0; f_rank[i] = 0;
      end
      for (int i = 0; i < NG; i++) begin
         g_page[i] = '0; g_list[i] = '0; g_rank[i] = 0;
      end
      p_target = 0; p_evcnt = 0;
      for (int i = 0; i < 4; i++) cnt[i] = 0;
   endfunction

   function automatic void frame_to_front(int f, logic [1:0] l);
      for (int i = 0; i < NF; i++) if (f_list[i] == l) f_rank[i]++;
      f_list[f] = l; f_rank[f] = 0; cnt[l-1]++;
   endfunction

   function automatic void frame_drop(int f);
      logic [1:0] l;
      l = f_list[f];
      if (l == LIST_NONE) return;
      for (int i = 0; i < NF; i++)
         if (f_list[i] == l && f_rank[i] > f_rank[f]) f_rank[i]--;
      cnt[l-1]--; f_list[f] = LIST_NONE; f_rank[f] = 0;
   endfunction

   function automatic void ghost_drop(int g);
      logic [1:0] l;
      l = g_list[g];
      if (l == 0) return;
      for (int i = 0; i < NG; i++)
         if (g_list[i] == l && g_rank[i] > g_rank[g]) g_rank[i]--;
      cnt[l+1]--; g_list[g] = '0; g_rank[g] = 0;
   endfunction

   function automatic int ghost_tail(logic [1:0] l);
      int b;
      b = -1;
      for (int i = 0; i < NG; i++)
         if (g_list[i] == l && (b < 0 || g_rank[i] > g_rank[b])) b = i;
      return b;
   endfunction

   function automatic int ghost_lookup(logic [31:0] pg);
      for (int i = 0; i < NG; i++) if (g_list[i] != 0 && g_page[i] == pg) return i;
      return -1;
   endfunction

   function automatic void ghost_insert(logic [31:0] pg, logic [1:0] l);
      int g, slot;
      slot = -1;
      g = ghost_lookup(pg);
      if (g >= 0) ghost_drop(g);
      for (int i = 0; i < NG && slot < 0; i++) if (g_list[i] == 0) slot = i;
      if (slot < 0) begin
         slot = ghost_tail(l);
         if (slot < 0) slot = ghost_tail(2'd3 - l);
         if (slot < 0) return;
         ghost_drop(slot);
      end
      for (int i = 0; i < NG; i++) if (g_list[i] == l) g_rank[i]++;
      g_list[slot] = l; g_rank[slot] = 0; g_page[slot] = pg; cnt[l+1]++;
   endfunction

   function automatic int victim_from(logic [1:0] l);
      int b;
      b = -1;
      for (int i = 0; i < NF; i++)
         if (f_list[i] == l && f_ev[i] && (b < 0 || f_rank[i] > f_rank[b])) b = i;
      if (b < 0) return -1;
      ghost_insert(f_page[b], l);
      frame_drop(b);
      f_ev[b] = 1'b0;
      if (p_evcnt > 0) p_evcnt--;
      return b;
   endfunction

   function automatic rsp_type replacer_step(req_type r);
      rsp_type o;
      int f, g, d, b1, b2, v;
      f = r.frame_index;
      o = '0;
      o.status = STAT_OK;
      case (r.cmd)
         CMD_ACCESS: begin
            if (f_list[f] != LIST_NONE) begin
               frame_drop(f); frame_to_front(f, LIST_FREQ);
            end else begin
               g = ghost_lookup(r.page_number);
               if (g >= 0) begin
                  b1 = cnt[2]; b2 = cnt[3];
                  if (g_list[g] == 1) begin
                     d = (b1 >= b2 || b1 == 0) ? 1 : b2 / b1;
                     p_target += d;
                     if (p_target > p_cap) p_target = p_cap;
                  end else begin
                     d = (b2 >= b1 || b2 == 0) ? 1 : b1 / b2;
                     p_target = (d > p_target) ? 0 : p_target - d;
                  end
                  ghost_drop(g);
                  f_page[f] = r.page_number; f_ev[f] = 1'b1; p_evcnt++;
                  frame_to_front(f, LIST_FREQ);
               end else begin
                  if (cnt[0] + cnt[2] == p_cap) begin
                     if (cnt[2] > 0) ghost_drop(ghost_tail(1));
                  end else if (cnt[0] + cnt[1] + cnt[2] + cnt[3] == 2 * p_cap) begin
                     if (cnt[3] > 0) ghost_drop(ghost_tail(2));
                  end
                  f_page[f] = r.page_number; f_ev[f] = 1'b0;
                  frame_to_front(f, LIST_RECENT);
               end
            end
         end
         CMD_SET_EVICT: begin
            if (f_list[f] == LIST_NONE) o.status = STAT_UNKNOWN;
            else begin
               if (!f_ev[f] && r.evictable_flag) p_evcnt++;
               if (f_ev[f] && !r.evictable_flag && p_evcnt > 0) p_evcnt--;
               f_ev[f] = r.evictable_flag;
            end
         end
         CMD_REMOVE: begin
            if (f_list[f] != LIST_NONE && f_ev[f]) begin
               frame_drop(f); f_ev[f] = 1'b0;
               if (p_evcnt > 0) p_evcnt--;
            end
         end
         default: begin
            if (cnt[0] >= p_target) begin
               v = victim_from(LIST_RECENT);
               if (v < 0) v = victim_from(LIST_FREQ);
            end else begin
               v = victim_from(LIST_FREQ);
               if (v < 0) v = victim_from(LIST_RECENT);
            end
            if (v < 0) o.status = STAT_NO_VICTIM;
            else o.victim_frame = 6'(v);
         end
      endcase
      o.evictable_count = 7'(p_evcnt);
      return o;
   endfunction

   // stall the result side
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL arc_page_replacer");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected word %h", rsp_data);
            failed = 1;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status); failed = 1;
            end
            if (rsp_data.victim_frame !== e.victim_frame) begin
               $error("victim_frame exp %0d got %0d", e.victim_frame, rsp_data.victim_frame);
               failed = 1;
            end
            if (rsp_data.evictable_count !== e.evictable_count) begin
               $error("evictable_count exp %0d got %0d", e.evictable_count,
                      rsp_data.evictable_count);
               failed = 1;
            end
         end
      end
   end

   task automatic csr_write(logic [6:0] val);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= {25'd0, val};
      @(posedge clock);
      penable <= 1;
      @(posedge clock iff pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      p_cap = val;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // send one word; a checked row pushes the given result, else the prediction
   task automatic send_word(req_type r, bit typed, rsp_type want);
      rsp_type p;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock iff req_ready);
      p = replacer_step(r);
      if (typed && p !== want) begin
         $error("table row disagrees with predictor: %h vs %h", want, p); failed = 1;
      end
      pending_rsp.push_back(typed ? want : p);
   endtask

   function automatic req_type mk(logic [1:0] c, logic [5:0] f, logic [31:0] pg, logic fl);
      req_type r;
      r.cmd = c; r.frame_index = f; r.page_number = pg; r.evictable_flag = fl;
      return r;
   endfunction

   function automatic rsp_type rs(logic [1:0] s, logic [5:0] v, logic [6:0] n);
      rsp_type o;
      o.status = s; o.victim_frame = v; o.evictable_count = n;
      return o;
   endfunction

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } row_type;

   initial begin
      row_type tbl [$];
      logic [6:0] caps [6];
      int pool;
      logic [1:0] c;
      caps = '{7'd1, 7'd8, 7'd3, 7'd127, 7'd0, 7'd64};
      replacer_clear();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      tbl = '{
         '{mk(CMD_EVICT, 6'd0, 0, 0), 1, rs(STAT_NO_VICTIM, 0, 0)},
         '{mk(CMD_SET_EVICT, 6'd63, 0, 1), 1, rs(STAT_UNKNOWN, 0, 0)},
         '{mk(CMD_REMOVE, 6'd0, 0, 0), 1, rs(STAT_OK, 0, 0)},
         '{mk(CMD_ACCESS, 6'd0, 32'h0, 0), 1, rs(STAT_OK, 0, 0)},
         '{mk(CMD_ACCESS, 6'd63, 32'hFFFF_FFFF, 1), 1, rs(STAT_OK, 0, 0)},
         '{mk(CMD_EVICT, 6'd5, 0, 0), 1, rs(STAT_NO_VICTIM, 0, 0)},
         '{mk(CMD_SET_EVICT, 6'd0, 0, 1), 1, rs(STAT_OK, 0, 1)},
         '{mk(CMD_SET_EVICT, 6'd63, 0, 1), 1, rs(STAT_OK, 0, 2)},
         '{mk(CMD_SET_EVICT, 6'd63, 0, 0), 1, rs(STAT_OK, 0, 1)},
         '{mk(CMD_EVICT, 6'd0, 0, 0), 1, rs(STAT_OK, 0, 0)},
         '{mk(CMD_ACCESS, 6'd1, 32'h0, 0), 0, '0},
         '{mk(CMD_ACCESS, 6'd63, 0, 0), 0, '0},
         '{mk(CMD_SET_EVICT, 6'd63, 0, 1), 0, '0},
         '{mk(CMD_REMOVE, 6'd63, 0, 0), 0, '0},
         '{mk(CMD_ACCESS, 6'd2, 32'hFFFF_FFFF, 0), 0, '0},
         '{mk(CMD_SET_EVICT, 6'd1, 0, 1), 0, '0},
         '{mk(CMD_SET_EVICT, 6'd2, 0, 1), 0, '0},
         '{mk(CMD_EVICT, 6'd0, 0, 0), 0, '0},
         '{mk(CMD_EVICT, 6'd0, 0, 0), 0, '0},
         '{mk(CMD_ACCESS, 6'd3, 32'hFFFF_FFFF, 0), 0, '0},
         '{mk(CMD_ACCESS, 6'd4, 32'h0, 0), 0, '0},
         '{mk(CMD_EVICT, 6'd0, 0, 0), 0, '0}
      };
      foreach (tbl[i]) send_word(tbl[i].word, tbl[i].typed, tbl[i].want);
      drain();

      // capacities: extremes and middle values, back to reset value at the end
      foreach (caps[k]) begin
         csr_write(caps[k]);
         pool = (k % 2) ? 24 : 8 + k * 4;
         for (int n = 0; n < 255; n++) begin
            if (k == 5 && n > 200) calm = 1;
            c = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
               send_word(mk(c, 6'($urandom), $urandom, 1'($urandom)), 0, '0);
            else
               send_word(mk(c, 6'($urandom_range(0, pool - 1)),
                            $urandom_range(0, pool * 2),
                            $urandom_range(0, 3) != 0), 0, '0);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("PASS arc_page_replacer");
      end else begin
         $display("FAIL arc_page_replacer");
      end
      $finish;
   end

endmodule

// ===== arc_page_replacer.f =====
src/arcpr_pkg.sv
src/arcpr_ram.sv
src/arc_page_replacer.sv
src/arcpr_chk.sv
tb/tb_arc_page_replacer.sv
